// ===== hw/rtl/rmj_pkg.sv =====
`timescale 1ns / 1ps
package rmj_pkg;

    localparam int FIELD_W   = 32;
    localparam int SQ_W      = 64;
    localparam int WIDE_W    = 96;
    localparam int CFG_W     = 16;
    localparam int QUOT_BITS = 32;
    localparam int ROOT_STEPS = 32;
    localparam int IN_W      = 4 * FIELD_W;
    localparam int OUT_W     = 6 * FIELD_W;

    localparam logic [FIELD_W-1:0] POS_MAX = 32'h7FFF_FFFF;
    localparam logic [FIELD_W-1:0] NEG_MIN = 32'h8000_0000;

    typedef struct packed {
        logic [FIELD_W-1:0] pm;
        logic [FIELD_W-1:0] qm;
        logic [SQ_W-1:0]    s;
        logic [WIDE_W-1:0]  pcq;
        logic [WIDE_W-1:0]  ppc;
        logic               neg_p;
        logic               neg_q;
        logic               cross_neg;
        logic               degen;
    } front_t;

    typedef struct packed {
        logic neg_p;
        logic neg_q;
        logic cross_neg;
        logic degen;
    } side_t;

    // magnitude (quotient plus overflow) to signed field, saturating
    function automatic logic [FIELD_W-1:0] to_field(input logic [QUOT_BITS-1:0] q,
                                                    input logic ovf, input logic neg);
        logic [FIELD_W-1:0] f;
        f = '0;
        if (ovf || q != '0) begin
            if (neg) begin
                if (ovf || q > NEG_MIN) f = NEG_MIN;
                else f = FIELD_W'(0) - q;
            end else begin
                if (ovf || q[QUOT_BITS-1]) f = POS_MAX;
                else f = q;
            end
        end
        return f;
    endfunction

endpackage

// ===== hw/rtl/rmj_delay.sv =====
`timescale 1ns / 1ps
module rmj_delay import rmj_pkg::*; #(
    parameter int W     = 4,
    parameter int DEPTH = 33
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         en,
    input  logic         in_vld,
    input  logic [W-1:0] in_dat,
    output logic         out_vld,
    output logic [W-1:0] out_dat
);

    logic         vld_reg [0:DEPTH-1];
    logic [W-1:0] dat_reg [0:DEPTH-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DEPTH; i++) vld_reg[i] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= in_vld;
            for (int i = 1; i < DEPTH; i++) vld_reg[i] <= vld_reg[i-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dat_reg[0] <= in_dat;
            for (int i = 1; i < DEPTH; i++) dat_reg[i] <= dat_reg[i-1];
        end
    end

    assign out_vld = vld_reg[DEPTH-1];
    assign out_dat = dat_reg[DEPTH-1];

endmodule

// ===== hw/rtl/rmj_front.sv =====
`timescale 1ns / 1ps
module rmj_front import rmj_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_vld,
    input  logic [IN_W-1:0]   in_dat,
    input  logic [CFG_W-1:0]  min_sq,
    output logic              out_vld,
    output front_t            out_dat
);

    // stage 1: input register
    logic               vld1_reg;
    logic signed [FIELD_W-1:0] p1_reg, q1_reg, u1_reg, v1_reg;

    // stage 2: products
    logic               vld2_reg;
    logic signed [SQ_W-1:0] pp2_reg, qq2_reg, a2_reg, b2_reg;
    logic [FIELD_W-1:0] pm2_reg, qm2_reg;
    logic               np2_reg, nq2_reg;

    // stage 3: range squared, cross term, threshold
    logic               vld3_reg;
    logic [SQ_W-1:0]    s3_reg, cm3_reg;
    logic [FIELD_W-1:0] pm3_reg, qm3_reg;
    logic               np3_reg, nq3_reg, cn3_reg, dg3_reg;
    logic [SQ_W-1:0]    s3_next;
    logic signed [SQ_W:0] cross_next;
    logic [SQ_W-1:0]    thr;

    // stage 4: partial products of magnitude by cross term
    logic               vld4_reg;
    logic [SQ_W-1:0]    qcl4_reg, qch4_reg, pcl4_reg, pch4_reg, s4_reg;
    logic [FIELD_W-1:0] pm4_reg, qm4_reg;
    logic               np4_reg, nq4_reg, cn4_reg, dg4_reg;

    // stage 5: partial product sums
    logic               vld5_reg;
    front_t             f5_reg;

    assign s3_next    = SQ_W'(pp2_reg) + SQ_W'(qq2_reg);
    assign cross_next = {a2_reg[SQ_W-1], a2_reg} - {b2_reg[SQ_W-1], b2_reg};
    assign thr        = SQ_W'(min_sq) << FRAC_BITS;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
            vld4_reg <= 1'b0;
            vld5_reg <= 1'b0;
        end else if (en) begin
            vld1_reg <= in_vld;
            vld2_reg <= vld1_reg;
            vld3_reg <= vld2_reg;
            vld4_reg <= vld3_reg;
            vld5_reg <= vld4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p1_reg <= in_dat[FIELD_W-1:0];
            q1_reg <= in_dat[2*FIELD_W-1:FIELD_W];
            u1_reg <= in_dat[3*FIELD_W-1:2*FIELD_W];
            v1_reg <= in_dat[4*FIELD_W-1:3*FIELD_W];

            pp2_reg <= p1_reg * p1_reg;
            qq2_reg <= q1_reg * q1_reg;
            a2_reg  <= u1_reg * q1_reg;
            b2_reg  <= v1_reg * p1_reg;
            pm2_reg <= p1_reg[FIELD_W-1] ? FIELD_W'(0) - p1_reg : p1_reg;
            qm2_reg <= q1_reg[FIELD_W-1] ? FIELD_W'(0) - q1_reg : q1_reg;
            np2_reg <= p1_reg[FIELD_W-1];
            nq2_reg <= q1_reg[FIELD_W-1];

            s3_reg  <= s3_next;
            cm3_reg <= cross_next[SQ_W] ? SQ_W'(-cross_next) : cross_next[SQ_W-1:0];
            cn3_reg <= cross_next[SQ_W];
            dg3_reg <= (s3_next == '0) || (s3_next < thr);
            pm3_reg <= pm2_reg;
            qm3_reg <= qm2_reg;
            np3_reg <= np2_reg;
            nq3_reg <= nq2_reg;

            qcl4_reg <= qm3_reg * cm3_reg[FIELD_W-1:0];
            qch4_reg <= qm3_reg * cm3_reg[SQ_W-1:FIELD_W];
            pcl4_reg <= pm3_reg * cm3_reg[FIELD_W-1:0];
            pch4_reg <= pm3_reg * cm3_reg[SQ_W-1:FIELD_W];
            s4_reg   <= s3_reg;
            pm4_reg  <= pm3_reg;
            qm4_reg  <= qm3_reg;
            np4_reg  <= np3_reg;
            nq4_reg  <= nq3_reg;
            cn4_reg  <= cn3_reg;
            dg4_reg  <= dg3_reg;

            f5_reg.pm        <= pm4_reg;
            f5_reg.qm        <= qm4_reg;
            f5_reg.s         <= s4_reg;
            f5_reg.pcq       <= WIDE_W'(qcl4_reg) + (WIDE_W'(qch4_reg) << FIELD_W);
            f5_reg.ppc       <= WIDE_W'(pcl4_reg) + (WIDE_W'(pch4_reg) << FIELD_W);
            f5_reg.neg_p     <= np4_reg;
            f5_reg.neg_q     <= nq4_reg;
            f5_reg.cross_neg <= cn4_reg;
            f5_reg.degen     <= dg4_reg;
        end
    end

    assign out_vld = vld5_reg;
    assign out_dat = f5_reg;

endmodule

// ===== hw/rtl/rmj_isqrt.sv =====
`timescale 1ns / 1ps
module rmj_isqrt import rmj_pkg::*; (
    input  logic               aclk,
    input  logic               en,
    input  logic [SQ_W-1:0]    s,
    output logic [FIELD_W-1:0] root
);

    logic [SQ_W-1:0] sv_reg  [0:ROOT_STEPS-1];
    logic [SQ_W-1:0] res_reg [0:ROOT_STEPS-1];

    // one result bit per stage, test bit walks down from bit 62 two at a time
    for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_step
        localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (SQ_W - 2 - 2 * k);
        logic [SQ_W-1:0] sv_in, res_in, trial;
        logic            ge;
        if (k == 0) begin : g_first
            assign sv_in  = s;
            assign res_in = '0;
        end else begin : g_rest
            assign sv_in  = sv_reg[k-1];
            assign res_in = res_reg[k-1];
        end
        assign trial = res_in + BIT;
        assign ge    = sv_in >= trial;
        always_ff @(posedge aclk) begin
            if (en) begin
                sv_reg[k]  <= ge ? sv_in - trial : sv_in;
                res_reg[k] <= ge ? (res_in >> 1) + BIT : res_in >> 1;
            end
        end
    end

    assign root = res_reg[ROOT_STEPS-1][FIELD_W-1:0];

endmodule

// ===== hw/rtl/rmj_div.sv =====
`timescale 1ns / 1ps
module rmj_div import rmj_pkg::*; #(
    parameter int NW = 48,
    parameter int DW = 32
) (
    input  logic                 aclk,
    input  logic                 en,
    input  logic [NW-1:0]        num,
    input  logic [DW-1:0]        den,
    output logic [QUOT_BITS-1:0] quot,
    output logic                 ovf
);

    localparam int HW = NW - QUOT_BITS;
    localparam int CW = (HW > DW) ? HW : DW;

    logic [DW-1:0]        rem_reg [0:QUOT_BITS];
    logic [DW-1:0]        den_reg [0:QUOT_BITS];
    logic [QUOT_BITS-1:0] nlo_reg [0:QUOT_BITS];
    logic [QUOT_BITS-1:0] q_reg   [0:QUOT_BITS];
    logic                 ovf_reg [0:QUOT_BITS];

    // quotient of 2^32 or more saturates downstream anyway
    always_ff @(posedge aclk) begin
        if (en) begin
            ovf_reg[0] <= CW'(num[NW-1:QUOT_BITS]) >= CW'(den);
            rem_reg[0] <= DW'(num[NW-1:QUOT_BITS]);
            nlo_reg[0] <= num[QUOT_BITS-1:0];
            den_reg[0] <= den;
            q_reg[0]   <= '0;
        end
    end

    for (genvar k = 1; k <= QUOT_BITS; k++) begin : g_step
        logic [DW:0] rs, diff;
        logic        ge;
        assign rs   = {rem_reg[k-1], nlo_reg[k-1][QUOT_BITS-1]};
        assign ge   = rs >= {1'b0, den_reg[k-1]};
        assign diff = rs - {1'b0, den_reg[k-1]};
        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k] <= ge ? diff[DW-1:0] : rs[DW-1:0];
                nlo_reg[k] <= nlo_reg[k-1] << 1;
                q_reg[k]   <= {q_reg[k-1][QUOT_BITS-2:0], ge};
                den_reg[k] <= den_reg[k-1];
                ovf_reg[k] <= ovf_reg[k-1];
            end
        end
    end

    assign quot = q_reg[QUOT_BITS];
    assign ovf  = ovf_reg[QUOT_BITS];

endmodule

// ===== hw/rtl/radar_measurement_jacobian_top.sv =====
`timescale 1ns / 1ps
// Pipeline from s_tdata request to m_tvalid: 5 front stages, 32 root stages,
// 2 range-product stages, 33 divider stages and an output register.
// Throughput: one request per cycle; s_tready drops only while the skid slot
// holds a result behind a stalled output.
// Reset: synchronous active-low aresetn empties the pipe and sets
// min_square_range back to 7.
module radar_measurement_jacobian_top import rmj_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CFG_W-1:0]  cfg_data,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [IN_W-1:0]   s_tdata,   // pos_x, pos_y, vel_x, vel_y
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_W-1:0]  m_tdata,   // drange_dpx, drange_dpy, dbearing_dpx,
                                         // dbearing_dpy, drate_dpx, drate_dpy
    output logic              m_tuser    // degenerate
);

    localparam int N1W = FIELD_W + FRAC_BITS;
    localparam int N2W = FIELD_W + 2 * FRAC_BITS;
    localparam int N3W = WIDE_W + FRAC_BITS;

    logic [CFG_W-1:0] min_sq_reg;
    logic             en;

    logic             f_vld, d_vld;
    front_t           f_dat, d_dat;
    logic [FIELD_W-1:0] root;

    logic             vm1_reg, vm2_reg;
    front_t           dm1_reg, dm2_reg;
    logic [FIELD_W-1:0] rm1_reg, rm2_reg;
    logic [SQ_W-1:0]  srl_reg, srh_reg;
    logic [WIDE_W-1:0] sr_reg;

    logic [QUOT_BITS-1:0] q0, q1, q2, q3, q4, q5;
    logic             o0, o1, o2, o3, o4, o5;
    side_t            side_in, side_out;
    logic             side_vld;

    logic [OUT_W-1:0] res_dat;
    logic             out_vld_reg, skid_vld_reg;
    logic [OUT_W-1:0] out_dat_reg, skid_dat_reg;
    logic             out_user_reg, skid_user_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_sq_reg <= CFG_W'(7);
        end else if (cfg_valid && cfg_ready) begin
            min_sq_reg <= cfg_data;
        end
    end

    // whole pipe moves unless the skid slot is occupied
    assign en       = !skid_vld_reg;
    assign s_tready = en;

    rmj_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .in_vld  (s_tvalid),
        .in_dat  (s_tdata),
        .min_sq  (min_sq_reg),
        .out_vld (f_vld),
        .out_dat (f_dat)
    );

    rmj_isqrt u_sqrt (
        .aclk (aclk),
        .en   (en),
        .s    (f_dat.s),
        .root (root)
    );

    rmj_delay #(.W($bits(front_t)), .DEPTH(ROOT_STEPS)) u_dly_root (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .in_vld  (f_vld),
        .in_dat  (f_dat),
        .out_vld (d_vld),
        .out_dat (d_dat)
    );

    // s * r in two 32-bit slices, then summed
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vm1_reg <= 1'b0;
            vm2_reg <= 1'b0;
        end else if (en) begin
            vm1_reg <= d_vld;
            vm2_reg <= vm1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            srl_reg <= d_dat.s[FIELD_W-1:0] * root;
            srh_reg <= d_dat.s[SQ_W-1:FIELD_W] * root;
            dm1_reg <= d_dat;
            rm1_reg <= root;
            sr_reg  <= WIDE_W'(srl_reg) + (WIDE_W'(srh_reg) << FIELD_W);
            dm2_reg <= dm1_reg;
            rm2_reg <= rm1_reg;
        end
    end

    rmj_div #(.NW(N1W), .DW(FIELD_W)) u_div_rpx (
        .aclk (aclk), .en (en),
        .num  (N1W'(dm2_reg.pm) << FRAC_BITS), .den (rm2_reg),
        .quot (q0), .ovf (o0)
    );
    rmj_div #(.NW(N1W), .DW(FIELD_W)) u_div_rpy (
        .aclk (aclk), .en (en),
        .num  (N1W'(dm2_reg.qm) << FRAC_BITS), .den (rm2_reg),
        .quot (q1), .ovf (o1)
    );
    rmj_div #(.NW(N2W), .DW(SQ_W)) u_div_bpx (
        .aclk (aclk), .en (en),
        .num  (N2W'(dm2_reg.qm) << (2 * FRAC_BITS)), .den (dm2_reg.s),
        .quot (q2), .ovf (o2)
    );
    rmj_div #(.NW(N2W), .DW(SQ_W)) u_div_bpy (
        .aclk (aclk), .en (en),
        .num  (N2W'(dm2_reg.pm) << (2 * FRAC_BITS)), .den (dm2_reg.s),
        .quot (q3), .ovf (o3)
    );
    rmj_div #(.NW(N3W), .DW(WIDE_W)) u_div_cpx (
        .aclk (aclk), .en (en),
        .num  (N3W'(dm2_reg.pcq) << FRAC_BITS), .den (sr_reg),
        .quot (q4), .ovf (o4)
    );
    rmj_div #(.NW(N3W), .DW(WIDE_W)) u_div_cpy (
        .aclk (aclk), .en (en),
        .num  (N3W'(dm2_reg.ppc) << FRAC_BITS), .den (sr_reg),
        .quot (q5), .ovf (o5)
    );

    assign side_in.neg_p     = dm2_reg.neg_p;
    assign side_in.neg_q     = dm2_reg.neg_q;
    assign side_in.cross_neg = dm2_reg.cross_neg;
    assign side_in.degen     = dm2_reg.degen;

    rmj_delay #(.W($bits(side_t)), .DEPTH(QUOT_BITS + 1)) u_dly_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .in_vld  (vm2_reg),
        .in_dat  (side_in),
        .out_vld (side_vld),
        .out_dat (side_out)
    );

    always_comb begin
        res_dat = '0;
        if (!side_out.degen) begin
            res_dat = {to_field(q5, o5, side_out.neg_p == side_out.cross_neg),
                       to_field(q4, o4, side_out.neg_q != side_out.cross_neg),
                       to_field(q3, o3, side_out.neg_p),
                       to_field(q2, o2, !side_out.neg_q),
                       to_field(q1, o1, side_out.neg_q),
                       to_field(q0, o0, side_out.neg_p)};
        end
    end

    // output register with one skid slot
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else begin
            if (!out_vld_reg || m_tready) begin
                out_vld_reg <= skid_vld_reg || side_vld;
            end
            if (skid_vld_reg) begin
                if (m_tready) skid_vld_reg <= 1'b0;
            end else if (side_vld && out_vld_reg && !m_tready) begin
                skid_vld_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_vld_reg || m_tready) begin
            if (skid_vld_reg) begin
                out_dat_reg  <= skid_dat_reg;
                out_user_reg <= skid_user_reg;
            end else begin
                out_dat_reg  <= res_dat;
                out_user_reg <= side_out.degen;
            end
        end
        if (!skid_vld_reg) begin
            skid_dat_reg  <= res_dat;
            skid_user_reg <= side_out.degen;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_dat_reg;
    assign m_tuser  = out_user_reg;

endmodule

// ===== hw/rtl/rmj_chk.sv =====
`timescale 1ns / 1ps
module rmj_chk import rmj_pkg::*; (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_tready,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [OUT_W-1:0]  m_tdata,
    input logic              m_tuser
);

    // a stalled result keeps its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // degenerate results carry an all-zero matrix
    a_degen_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("degenerate result with non-zero entries");

    // input back-pressure only with a result waiting at the output
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with empty output");

    // reset empties the output
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result present after reset");

endmodule

bind radar_measurement_jacobian_top rmj_chk u_rmj_chk (.*);

// ===== test/radar_measurement_jacobian_top_tb.sv =====
`timescale 1ns / 1ps
module radar_measurement_jacobian_top_tb;
    import rmj_pkg::*;

    localparam int WATCHDOG_LIMIT = 6000;
    localparam int DRAIN_CYCLES   = 90;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    logic              aclk;
    logic              aresetn;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [CFG_W-1:0]  cfg_data;
    logic              s_tvalid;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata;   // pos_x, pos_y, vel_x, vel_y
    logic              m_tvalid;
    logic              m_tready;
    logic [OUT_W-1:0]  m_tdata;   // drange_dpx, drange_dpy, dbearing_dpx,
                                  // dbearing_dpy, drate_dpx, drate_dpy
    logic              m_tuser;   // degenerate

    radar_measurement_jacobian_top i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always begin
        aclk = 1'b1; #4;
        aclk = 1'b0; #4;
    end

    logic [CFG_W-1:0]  min_sq_range;
    logic [OUT_W:0]    jacobian_q[$];   // degenerate flag on top
    idle_mode_t        idle_mode;
    int                hold_off;
    int                mismatches;
    int                quiet_cycles;

    // ---------------- predictor ----------------
    function automatic logic [63:0] int_sqrt(input logic [63:0] s);
        logic [63:0]  res;
        logic [63:0]  t;
        res = '0;
        for (int i = 31; i >= 0; i--) begin
            t = res | (64'd1 << i);
            if (128'(t) * 128'(t) <= 128'(s)) res = t;
        end
        return res;
    endfunction

    function automatic logic [FIELD_W-1:0] sat_field(input logic [127:0] mag, input bit neg);
        if (mag == 0) return '0;
        if (neg) return (mag >= 128'h8000_0000) ? NEG_MIN : FIELD_W'(0) - mag[31:0];
        return (mag >= 128'h8000_0000) ? POS_MAX : mag[31:0];
    endfunction

    function automatic logic [OUT_W:0] jacobian_of(input logic [IN_W-1:0] d,
                                                   input logic [CFG_W-1:0] thr);
        longint p, q, u, v;
        logic [63:0] pm, qm, s, r;
        logic signed [65:0] a, b, diff;
        logic [127:0] cm, w;
        bit cneg;
        logic [OUT_W-1:0] o;
        p = longint'(signed'(d[31:0]));
        q = longint'(signed'(d[63:32]));
        u = longint'(signed'(d[95:64]));
        v = longint'(signed'(d[127:96]));
        pm = p < 0 ? -p : p;
        qm = q < 0 ? -q : q;
        s = pm * pm + qm * qm;
        if (s == 0 || s < (64'(thr) << 16)) return {1'b1, {OUT_W{1'b0}}};
        r = int_sqrt(s);
        o[31:0]   = sat_field((128'(pm) << 16) / r, p < 0);
        o[63:32]  = sat_field((128'(qm) << 16) / r, q < 0);
        o[95:64]  = sat_field((128'(qm) << 32) / s, q > 0);
        o[127:96] = sat_field((128'(pm) << 32) / s, p < 0);
        a = u * q;
        b = v * p;
        diff = a - b;
        cneg = diff < 0;
        cm = cneg ? 128'(-diff) : 128'(diff);
        w = ((128'(qm) * cm) << 16) / s;
        if (w > 128'h7FFF_FFFF_FFFF_FFFF) w = 128'h7FFF_FFFF_FFFF_FFFF;
        o[159:128] = sat_field(w / r, (q < 0) != cneg);
        w = ((128'(pm) * cm) << 16) / s;
        if (w > 128'h7FFF_FFFF_FFFF_FFFF) w = 128'h7FFF_FFFF_FFFF_FFFF;
        o[191:160] = sat_field(w / r, (p < 0) == cneg);
        return {1'b0, o};
    endfunction

    // ---------------- checking ----------------
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            logic [OUT_W:0] want;
            if (jacobian_q.size() == 0) begin
                report_mismatch("unexpected result", m_tdata[31:0], '0);
            end else begin
                want = jacobian_q.pop_front();
                for (int k = 0; k < 6; k++)
                    if (m_tdata[32*k +: 32] !== want[32*k +: 32])
                        report_mismatch($sformatf("entry %0d", k),
                                        m_tdata[32*k +: 32], want[32*k +: 32]);
                if (m_tuser !== want[OUT_W])
                    report_mismatch("degenerate", 32'(m_tuser), 32'(want[OUT_W]));
            end
        end
    end

    // receiver: random stalls, long hold-off when requested
    always @(negedge aclk) begin
        if (hold_off > 0) begin
            m_tready <= 1'b0;
            hold_off <= hold_off - 1;
        end else case (idle_mode)
            IDLE_RECEIVER: m_tready <= ($urandom_range(99) >= 63);
            IDLE_BOTH:     m_tready <= ($urandom_range(99) >= 12);
            default:       m_tready <= 1'b1;
        endcase
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // ---------------- stimulus ----------------
    task automatic send_state(input logic [IN_W-1:0] d);
        int pct;
        pct = (idle_mode == IDLE_SENDER) ? 63 : (idle_mode == IDLE_BOTH) ? 12 : 0;
        while ($urandom_range(99) < pct) begin
            @(negedge aclk);
            s_tvalid = 1'b0;
        end
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tdata  = d;
        do @(posedge aclk); while (!s_tready);
        jacobian_q.push_back(jacobian_of(d, min_sq_range));
    endtask

    task automatic wait_idle();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (jacobian_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_threshold(input logic [CFG_W-1:0] val);
        wait_idle();
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_data  = val;
        do @(posedge aclk); while (!cfg_ready);
        min_sq_range = val;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    function automatic logic [31:0] rand_field();
        case ($urandom_range(5))
            0, 1: return $urandom;
            2:    return 32'(signed'($urandom_range(2 * 1048576)) - 1048576);
            3:    return 32'(signed'($urandom_range(1200)) - 600);
            4:    return $urandom_range(1) ? POS_MAX - $urandom_range(3)
                                           : NEG_MIN + $urandom_range(3);
            default: return 32'(signed'($urandom_range(2 * 16777216)) - 16777216);
        endcase
    endfunction

    function automatic logic [IN_W-1:0] rand_state();
        return {rand_field(), rand_field(), rand_field(), rand_field()};
    endfunction

    task automatic test_directed();
        idle_mode = IDLE_NONE;
        send_state('0);                                        // zero range
        send_state({32'd0, 32'd0, 32'd0, 32'd677});            // just below threshold
        send_state({32'd0, 32'd0, 32'd0, 32'd678});            // just above
        send_state({32'd5, 32'd7, 32'd0, 32'd678});
        send_state({NEG_MIN, NEG_MIN, NEG_MIN, NEG_MIN});
        send_state({POS_MAX, POS_MAX, POS_MAX, POS_MAX});
        send_state({NEG_MIN, POS_MAX, POS_MAX, NEG_MIN});
        send_state({32'h0001_0000, 32'hFFFF_0000, 32'h0003_0000, 32'h0004_0000});
        send_state({32'hFFFD_0000, 32'h0002_0000, 32'hFFFF_FFFC, 32'h0000_0003});
        send_state({POS_MAX, NEG_MIN, 32'd0, 32'd1});
        send_state({32'd1, 32'd0, 32'd700, 32'd700});
        send_state({32'd0, 32'd1, 32'h0010_0000, 32'h0000_1000});
    endtask

    task automatic test_threshold_extremes();
        write_threshold('0);
        send_state('0);                                        // still degenerate
        send_state({32'd0, 32'd0, 32'd0, 32'd1});              // r = 1, saturates
        send_state({32'd1, 32'd2, 32'd1, 32'd1});
        write_threshold(16'hFFFF);
        send_state({32'd0, 32'd0, 32'd0, 32'h00FF_FF00});
        send_state({32'd0, 32'd0, 32'h00FF_FFFF, 32'd0});
        send_state({POS_MAX, NEG_MIN, 32'h0100_0000, 32'd0});
    endtask

    task automatic test_random(input idle_mode_t mode, input int n);
        idle_mode = mode;
        repeat (n) send_state(rand_state());
    endtask

    task automatic test_backpressure();
        idle_mode = IDLE_NONE;
        @(negedge aclk);
        s_tvalid = 1'b0;
        hold_off = 400;
        repeat (150) send_state(rand_state());
    endtask

    initial begin
        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        hold_off = 0;
        mismatches = 0;
        quiet_cycles = 0;
        idle_mode = IDLE_NONE;
        min_sq_range = 16'd7;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_directed();
        test_threshold_extremes();
        write_threshold(16'd7);
        test_random(IDLE_NONE, 400);
        test_random(IDLE_SENDER, 350);
        write_threshold(CFG_W'($urandom_range(1, 65534)));
        test_random(IDLE_RECEIVER, 350);
        write_threshold(16'd300);
        test_random(IDLE_BOTH, 350);
        test_backpressure();
        write_threshold(16'd0);
        test_random(IDLE_BOTH, 150);
        wait_idle();

        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
